[rtl/jgv_pkg.sv]
// Package for the joint goal velocity controller.
// Command, status, state and ALU codes plus fixed field widths; no dependencies.
`default_nettype none

package jgv_pkg;

    localparam int JOINTS  = 7;   // joint 6 is the jaw
    localparam int JW      = 3;   // joint index width
    localparam int NMARGIN = 6;   // jaw has no margin
    localparam int CFG_W   = 15;  // config register width
    localparam int ADDR_W  = 5;   // 8 registers at 4 byte stride

    localparam logic [JW-1:0] JAW = JW'(JOINTS - 1);

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_MAX_VEL  = 3'd0;
    localparam logic [2:0] REG_DEADBAND = 3'd1;
    localparam logic [2:0] REG_MARGIN1  = 3'd2;

    typedef enum logic [2:0] {
        CMD_LOAD_LIMIT = 3'd0,
        CMD_SET_TARGET = 3'd1,
        CMD_START_GOAL = 3'd2,
        CMD_POSITION   = 3'd3,
        CMD_TICK       = 3'd4,
        CMD_CANCEL     = 3'd5
    } t_cmd;

    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_NOT_READY    = 4'd1,
        ST_OUT_OF_RANGE = 4'd2,
        ST_EMPTY_RANGE  = 4'd3,
        ST_MOVING       = 4'd4,
        ST_STOP         = 4'd5,
        ST_SUCCEEDED    = 4'd6,
        ST_CANCELED     = 4'd7,
        ST_NOT_ACTIVE   = 4'd8
    } t_status;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_LO,
        S_LD_HI,
        S_LD_CMP,
        S_ST_LO,
        S_ST_HI,
        S_TK_ERR,
        S_TK_VEL,
        S_ZRUN,
        S_EMIT
    } t_state;

    // write strobes into the joint register file
    typedef struct packed {
        logic          we_lim;
        logic          we_tgt;
        logic          we_pos;
        logic [JW-1:0] widx;
    } t_wr_ctl;

endpackage

`default_nettype wire

[rtl/jgv_alu.sv]
// Shared add/subtract unit with sign flag and saturation to the position range.
// Depends on jgv_pkg (ALU op codes).
`default_nettype none

module jgv_alu #(
    parameter int POS_WIDTH = 16
) (
    input  jgv_pkg::t_alu_op i_op,
    input  logic signed [((POS_WIDTH + 2 > 17) ? POS_WIDTH + 2 : 17)-1:0] i_a,
    input  logic signed [((POS_WIDTH + 2 > 17) ? POS_WIDTH + 2 : 17)-1:0] i_b,
    output logic signed [((POS_WIDTH + 2 > 17) ? POS_WIDTH + 2 : 17)-1:0] o_sum,
    output logic                                                           o_neg,
    output logic        [POS_WIDTH-1:0]                                    o_sat
);

    localparam int CW = (POS_WIDTH + 2 > 17) ? POS_WIDTH + 2 : 17;
    localparam logic signed [CW-1:0] PMAX_C = (CW'(1) << (POS_WIDTH - 1)) - CW'(1);
    localparam logic signed [CW-1:0] PMIN_C = ~PMAX_C;

    logic signed [CW-1:0] sum;

    assign sum   = (i_op == jgv_pkg::ALU_SUB) ? (i_a - i_b) : (i_a + i_b);
    assign o_sum = sum;
    assign o_neg = sum[CW-1];

    always_comb begin
        if (sum > PMAX_C) begin
            o_sat = PMAX_C[POS_WIDTH-1:0];
        end else if (sum < PMIN_C) begin
            o_sat = PMIN_C[POS_WIDTH-1:0];
        end else begin
            o_sat = sum[POS_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire

[rtl/jgv_regfile.sv]
// Per-joint storage: shrunk limits, targets and measured positions.
// Depends on jgv_pkg (joint count, write control struct).
`default_nettype none

module jgv_regfile #(
    parameter int POS_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  jgv_pkg::t_wr_ctl        i_wr,
    input  logic [POS_WIDTH-1:0]    i_wr_lo,
    input  logic [POS_WIDTH-1:0]    i_wr_hi,
    input  logic [POS_WIDTH-1:0]    i_wr_val,
    input  logic [jgv_pkg::JW-1:0]  i_ridx,
    output logic [POS_WIDTH-1:0]    o_lo,
    output logic [POS_WIDTH-1:0]    o_hi,
    output logic [POS_WIDTH-1:0]    o_tgt,
    output logic [POS_WIDTH-1:0]    o_pos
);

    localparam logic [POS_WIDTH-1:0] RST_LO = {1'b1, {(POS_WIDTH - 1){1'b0}}};
    localparam logic [POS_WIDTH-1:0] RST_HI = {1'b0, {(POS_WIDTH - 1){1'b1}}};

    logic [POS_WIDTH-1:0] r_lo  [jgv_pkg::JOINTS];
    logic [POS_WIDTH-1:0] r_hi  [jgv_pkg::JOINTS];
    logic [POS_WIDTH-1:0] r_tgt [jgv_pkg::JOINTS];
    logic [POS_WIDTH-1:0] r_pos [jgv_pkg::JOINTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < jgv_pkg::JOINTS; k++) begin
                r_lo[k]  <= RST_LO;
                r_hi[k]  <= RST_HI;
                r_tgt[k] <= '0;
                r_pos[k] <= '0;
            end
        end else begin
            if (i_wr.we_lim) begin
                r_lo[i_wr.widx] <= i_wr_lo;
                r_hi[i_wr.widx] <= i_wr_hi;
            end
            if (i_wr.we_tgt) begin
                r_tgt[i_wr.widx] <= i_wr_val;
            end
            if (i_wr.we_pos) begin
                r_pos[i_wr.widx] <= i_wr_val;
            end
        end
    end

    assign o_lo  = r_lo[i_ridx];
    assign o_hi  = r_hi[i_ridx];
    assign o_tgt = r_tgt[i_ridx];
    assign o_pos = r_pos[i_ridx];

endmodule

`default_nettype wire

[rtl/joint_goal_velocity_controller.sv]
// Joint goal velocity controller: sequencer, config registers and output stage.
// Depends on jgv_pkg, jgv_alu and jgv_regfile.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall): one command item (load limit, set
//    target, start goal, position, tick, cancel). o_in_stall is high while an
//    item is being worked on; the block handles one item at a time.
//  - Output channel (o_out_valid / i_out_stall): result items, one per cycle at
//    most, o_last set on the final result of an input item. A one-entry output
//    register holds a stalled result; the sequencer waits until it can write.
//  - APB port: max_velocity, deadband, margin_joint1..6 at byte 0,4,..,28.
//    Write only while the block is idle.
// Work per command item, in sequencer order:
//  - set target / position, single-result cases: the write or check, then the result.
//  - load limit: add, subtract, compare on the shared ALU, then the result.
//  - start goal: two ALU compares per unmasked joint, then the result.
//  - tick: error subtract and deadband compare per joint, one result each,
//    plus the succeeded run; cancel and canceled ticks: a run over all joints.
//  The single shared ALU serializes these steps.
// Reset (synchronous, active low) restores limits to the full range, clears
// targets, positions, loaded flags and goal state, and reloads register defaults.
`default_nettype none

module joint_goal_velocity_controller #(
    parameter int POS_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // command items
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [2:0]                         i_cmd,
    input  logic [jgv_pkg::JW-1:0]             i_joint,
    input  logic signed [POS_WIDTH-1:0]        i_value_a,
    input  logic signed [POS_WIDTH-1:0]        i_value_b,
    input  logic [jgv_pkg::JOINTS-1:0]         i_ignore_mask,
    // result items
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [jgv_pkg::JW-1:0]             o_joint_res,
    output logic signed [POS_WIDTH-1:0]        o_velocity,
    output logic [3:0]                         o_status,
    output logic                               o_last,
    // APB configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [jgv_pkg::ADDR_W-1:0]         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int CW = (POS_WIDTH + 2 > 17) ? POS_WIDTH + 2 : 17;  // ALU width
    localparam int EW = POS_WIDTH + 1;                               // error width
    localparam int PW = POS_WIDTH;
    localparam int CFW = jgv_pkg::CFG_W;
    localparam logic signed [CW-1:0] PMAX_C = (CW'(1) << (POS_WIDTH - 1)) - CW'(1);
    localparam logic [jgv_pkg::JOINTS-1:0] ALL_LOADED = '1;

    function automatic logic signed [CW-1:0] sx(input logic [PW-1:0] v);
        sx = {{(CW - PW){v[PW-1]}}, v};
    endfunction

    function automatic logic signed [CW-1:0] zx(input logic [CFW-1:0] v);
        zx = {{(CW - CFW){1'b0}}, v};
    endfunction

    // ---------------------------------------------------------------- config
    logic [CFW-1:0] r_max_vel;
    logic [CFW-1:0] r_deadband;
    logic [CFW-1:0] r_margin [jgv_pkg::NMARGIN];
    logic [2:0]     reg_idx;
    logic           cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_vel  <= CFW'(2048);
            r_deadband <= CFW'(410);
            for (int k = 0; k < jgv_pkg::NMARGIN; k++) begin
                r_margin[k] <= CFW'(410);
            end
        end else if (cfg_wr) begin
            unique case (reg_idx)
                jgv_pkg::REG_MAX_VEL:  r_max_vel  <= pwdata[CFW-1:0];
                jgv_pkg::REG_DEADBAND: r_deadband <= pwdata[CFW-1:0];
                default:               r_margin[reg_idx - jgv_pkg::REG_MARGIN1] <= pwdata[CFW-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            jgv_pkg::REG_MAX_VEL:  prdata = 32'(r_max_vel);
            jgv_pkg::REG_DEADBAND: prdata = 32'(r_deadband);
            default:               prdata = 32'(r_margin[reg_idx - jgv_pkg::REG_MARGIN1]);
        endcase
    end

    // ------------------------------------------------------------- sequencer
    jgv_pkg::t_state  r_state, n_state;
    logic [jgv_pkg::JW-1:0]     r_joint, n_joint;   // joint of a single result
    logic [PW-1:0]              r_va, n_va;
    logic [PW-1:0]              r_vb, n_vb;
    logic [jgv_pkg::JOINTS-1:0] r_imask, n_imask;
    logic [jgv_pkg::JW-1:0]     r_idx, n_idx;       // joint walk index
    logic [PW-1:0]              r_lo, n_lo;
    logic [PW-1:0]              r_hi, n_hi;
    logic [EW-1:0]              r_err, n_err;
    logic                       r_alldone, n_alldone;
    jgv_pkg::t_status           r_code, n_code;
    logic [jgv_pkg::JOINTS-1:0] r_loaded, n_loaded;
    logic [jgv_pkg::JOINTS-1:0] r_gmask, n_gmask;
    logic                       r_active, n_active;
    logic                       r_pending, n_pending;

    // output stage
    logic                       r_ov;
    logic [jgv_pkg::JW-1:0]     r_o_joint;
    logic [PW-1:0]              r_o_vel;
    logic [3:0]                 r_o_status;
    logic                       r_o_last;

    logic                       in_acc;
    logic                       can_emit;
    logic                       emit;
    logic [jgv_pkg::JW-1:0]     e_joint;
    logic [PW-1:0]              e_vel;
    jgv_pkg::t_status           e_status;
    logic                       e_last;

    jgv_pkg::t_wr_ctl           wr;
    jgv_pkg::t_alu_op           alu_op;
    logic signed [CW-1:0]       alu_a, alu_b, alu_sum;
    logic                       alu_neg;
    logic [PW-1:0]              alu_sat;
    logic [PW-1:0]              rf_lo, rf_hi, rf_tgt, rf_pos;

    logic [CFW-1:0]             mg;
    logic                       err_neg;
    logic [EW-1:0]              mag;
    logic signed [CW-1:0]       mag_c, lim_c, vmag_c, vneg_c;
    logic [PW-1:0]              vel_calc;
    logic                       masked, moving, done_now;

    assign o_in_stall = (r_state != jgv_pkg::S_IDLE);
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign can_emit   = ~r_ov | ~i_out_stall;

    // jaw carries no margin
    assign mg = (r_joint < jgv_pkg::JW'(jgv_pkg::NMARGIN)) ? r_margin[r_joint] : '0;

    // velocity clamp: |err| limited to max_velocity and the position range
    assign err_neg  = r_err[EW-1];
    assign mag      = err_neg ? (~r_err + EW'(1)) : r_err;
    assign mag_c    = {{(CW - EW){1'b0}}, mag};
    assign lim_c    = (zx(r_max_vel) < PMAX_C) ? zx(r_max_vel) : PMAX_C;
    assign vmag_c   = (mag_c > lim_c) ? lim_c : mag_c;
    assign vneg_c   = -vmag_c;
    assign vel_calc = err_neg ? vneg_c[PW-1:0] : vmag_c[PW-1:0];
    assign masked   = r_gmask[r_idx];
    assign moving   = alu_neg & ~masked;    // deadband - |err| < 0
    assign done_now = r_alldone & ~moving;

    jgv_alu #(.POS_WIDTH(POS_WIDTH)) u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_sum (alu_sum),
        .o_neg (alu_neg),
        .o_sat (alu_sat)
    );

    jgv_regfile #(.POS_WIDTH(POS_WIDTH)) u_regfile (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (wr),
        .i_wr_lo  (r_lo),
        .i_wr_hi  (r_hi),
        .i_wr_val (i_value_a),
        .i_ridx   (r_idx),
        .o_lo     (rf_lo),
        .o_hi     (rf_hi),
        .o_tgt    (rf_tgt),
        .o_pos    (rf_pos)
    );

    always_comb begin
        n_state   = r_state;
        n_joint   = r_joint;
        n_va      = r_va;
        n_vb      = r_vb;
        n_imask   = r_imask;
        n_idx     = r_idx;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_err     = r_err;
        n_alldone = r_alldone;
        n_code    = r_code;
        n_loaded  = r_loaded;
        n_gmask   = r_gmask;
        n_active  = r_active;
        n_pending = r_pending;
        wr        = '0;
        alu_op    = jgv_pkg::ALU_ADD;
        alu_a     = '0;
        alu_b     = '0;
        emit      = 1'b0;
        e_joint   = '0;
        e_vel     = '0;
        e_status  = jgv_pkg::ST_OK;
        e_last    = 1'b0;

        unique case (r_state)
            jgv_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_joint = i_joint;
                    n_va    = i_value_a;
                    n_vb    = i_value_b;
                    n_imask = i_ignore_mask;
                    n_code  = jgv_pkg::ST_OK;
                    unique case (i_cmd)
                        jgv_pkg::CMD_LOAD_LIMIT: begin
                            if (i_joint < jgv_pkg::JW'(jgv_pkg::JOINTS)) begin
                                n_state = jgv_pkg::S_LD_LO;
                            end
                        end
                        jgv_pkg::CMD_SET_TARGET: begin
                            if (i_joint < jgv_pkg::JW'(jgv_pkg::JOINTS)) begin
                                wr.we_tgt = 1'b1;
                                wr.widx   = i_joint;
                                n_state   = jgv_pkg::S_EMIT;
                            end
                        end
                        jgv_pkg::CMD_POSITION: begin
                            if (i_joint < jgv_pkg::JW'(jgv_pkg::JOINTS)) begin
                                wr.we_pos = 1'b1;
                                wr.widx   = i_joint;
                                n_state   = jgv_pkg::S_EMIT;
                            end
                        end
                        jgv_pkg::CMD_START_GOAL: begin
                            if (r_loaded != ALL_LOADED) begin
                                n_joint = '0;
                                n_code  = jgv_pkg::ST_NOT_READY;
                                n_state = jgv_pkg::S_EMIT;
                            end else begin
                                n_idx   = '0;
                                n_state = jgv_pkg::S_ST_LO;
                            end
                        end
                        jgv_pkg::CMD_TICK: begin
                            n_idx = '0;
                            if (!r_active) begin
                                n_joint = '0;
                                n_code  = jgv_pkg::ST_NOT_ACTIVE;
                                n_state = jgv_pkg::S_EMIT;
                            end else if (r_pending) begin
                                n_active  = 1'b0;
                                n_pending = 1'b0;
                                n_code    = jgv_pkg::ST_CANCELED;
                                n_state   = jgv_pkg::S_ZRUN;
                            end else begin
                                n_alldone = 1'b1;
                                n_state   = jgv_pkg::S_TK_ERR;
                            end
                        end
                        jgv_pkg::CMD_CANCEL: begin
                            n_idx = '0;
                            if (r_active) begin
                                n_pending = 1'b1;
                                n_code    = jgv_pkg::ST_STOP;
                                n_state   = jgv_pkg::S_ZRUN;
                            end else begin
                                n_joint = '0;
                                n_code  = jgv_pkg::ST_NOT_ACTIVE;
                                n_state = jgv_pkg::S_EMIT;
                            end
                        end
                        default: begin
                            // unknown command: dropped without a result
                        end
                    endcase
                end
            end

            jgv_pkg::S_LD_LO: begin
                alu_op  = jgv_pkg::ALU_ADD;
                alu_a   = sx(r_va);
                alu_b   = zx(mg);
                n_lo    = alu_sat;
                n_state = jgv_pkg::S_LD_HI;
            end

            jgv_pkg::S_LD_HI: begin
                alu_op  = jgv_pkg::ALU_SUB;
                alu_a   = sx(r_vb);
                alu_b   = zx(mg);
                n_hi    = alu_sat;
                n_state = jgv_pkg::S_LD_CMP;
            end

            jgv_pkg::S_LD_CMP: begin
                // empty range when hi - lo < 0; limits are stored either way
                alu_op    = jgv_pkg::ALU_SUB;
                alu_a     = sx(r_hi);
                alu_b     = sx(r_lo);
                wr.we_lim = 1'b1;
                wr.widx   = r_joint;
                n_loaded[r_joint] = ~alu_neg;
                n_code    = alu_neg ? jgv_pkg::ST_EMPTY_RANGE : jgv_pkg::ST_OK;
                n_state   = jgv_pkg::S_EMIT;
            end

            jgv_pkg::S_ST_LO: begin
                alu_op = jgv_pkg::ALU_SUB;
                alu_a  = sx(rf_tgt);
                alu_b  = sx(rf_lo);
                if (!r_imask[r_idx] && alu_neg) begin
                    n_joint = r_idx;
                    n_code  = jgv_pkg::ST_OUT_OF_RANGE;
                    n_state = jgv_pkg::S_EMIT;
                end else if (!r_imask[r_idx]) begin
                    n_state = jgv_pkg::S_ST_HI;
                end else if (r_idx == jgv_pkg::JAW) begin
                    n_gmask   = r_imask;
                    n_active  = 1'b1;
                    n_pending = 1'b0;
                    n_joint   = '0;
                    n_state   = jgv_pkg::S_EMIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            jgv_pkg::S_ST_HI: begin
                alu_op = jgv_pkg::ALU_SUB;
                alu_a  = sx(rf_hi);
                alu_b  = sx(rf_tgt);
                if (alu_neg) begin
                    n_joint = r_idx;
                    n_code  = jgv_pkg::ST_OUT_OF_RANGE;
                    n_state = jgv_pkg::S_EMIT;
                end else if (r_idx == jgv_pkg::JAW) begin
                    n_gmask   = r_imask;
                    n_active  = 1'b1;
                    n_pending = 1'b0;
                    n_joint   = '0;
                    n_state   = jgv_pkg::S_EMIT;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = jgv_pkg::S_ST_LO;
                end
            end

            jgv_pkg::S_TK_ERR: begin
                alu_op  = jgv_pkg::ALU_SUB;
                alu_a   = sx(rf_tgt);
                alu_b   = sx(rf_pos);
                n_err   = alu_sum[EW-1:0];
                n_state = jgv_pkg::S_TK_VEL;
            end

            jgv_pkg::S_TK_VEL: begin
                alu_op = jgv_pkg::ALU_SUB;
                alu_a  = zx(r_deadband);
                alu_b  = mag_c;
                if (can_emit) begin
                    emit      = 1'b1;
                    e_joint   = r_idx;
                    e_vel     = moving ? vel_calc : '0;
                    e_status  = jgv_pkg::ST_MOVING;
                    e_last    = (r_idx == jgv_pkg::JAW) & ~done_now;
                    n_alldone = done_now;
                    if (r_idx == jgv_pkg::JAW) begin
                        n_idx = '0;
                        if (done_now) begin
                            n_active = 1'b0;
                            n_code   = jgv_pkg::ST_SUCCEEDED;
                            n_state  = jgv_pkg::S_ZRUN;
                        end else begin
                            n_state = jgv_pkg::S_IDLE;
                        end
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = jgv_pkg::S_TK_ERR;
                    end
                end
            end

            jgv_pkg::S_ZRUN: begin
                if (can_emit) begin
                    emit     = 1'b1;
                    e_joint  = r_idx;
                    e_status = r_code;
                    e_last   = (r_idx == jgv_pkg::JAW);
                    if (r_idx == jgv_pkg::JAW) begin
                        n_state = jgv_pkg::S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end

            jgv_pkg::S_EMIT: begin
                if (can_emit) begin
                    emit     = 1'b1;
                    e_joint  = r_joint;
                    e_status = r_code;
                    e_last   = 1'b1;
                    n_state  = jgv_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = jgv_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= jgv_pkg::S_IDLE;
            r_loaded  <= '0;
            r_gmask   <= '0;
            r_active  <= 1'b0;
            r_pending <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_loaded  <= n_loaded;
            r_gmask   <= n_gmask;
            r_active  <= n_active;
            r_pending <= n_pending;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_joint   <= n_joint;
        r_va      <= n_va;
        r_vb      <= n_vb;
        r_imask   <= n_imask;
        r_idx     <= n_idx;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_err     <= n_err;
        r_alldone <= n_alldone;
        r_code    <= n_code;
        if (emit) begin
            r_o_joint  <= e_joint;
            r_o_vel    <= e_vel;
            r_o_status <= e_status;
            r_o_last   <= e_last;
        end
    end

    assign o_out_valid = r_ov;
    assign o_joint_res = r_o_joint;
    assign o_velocity  = r_o_vel;
    assign o_status    = r_o_status;
    assign o_last      = r_o_last;

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for joint_goal_velocity_controller: directed and random command items,
// randomized input gaps and output stalls, APB register sweeps with readback.
// Depends on jgv_pkg and the RTL top level only.
`timescale 1ns / 1ps

module testbench;

    localparam int POS_W       = 16;
    localparam int POS_HI      = 32767;
    localparam int POS_LO      = -32768;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 40;    // well past the longest tick

    // command codes the block has no use for; they must be dropped silently
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    localparam logic [2:0] NO_JOINT    = 3'd7;

    typedef struct packed {
        logic [jgv_pkg::JW-1:0]  joint;
        logic signed [POS_W-1:0] vel;
        jgv_pkg::t_status        status;
        logic                    last;
    } t_result;

    // Predicts what each command item produces and checks results in order.
    class goal_scoreboard;
        int unsigned vel_limit, arrive_band;
        int unsigned margin_of[jgv_pkg::NMARGIN];
        int          lo_lim[jgv_pkg::JOINTS], hi_lim[jgv_pkg::JOINTS];
        int          tgt[jgv_pkg::JOINTS], pos[jgv_pkg::JOINTS];
        logic [jgv_pkg::JOINTS-1:0] loaded, skip_mask;
        bit          active, cancel_armed;
        t_result     due_q[$];
        int          errors, checked;

        function new();
            vel_limit   = 2048;
            arrive_band = 410;
            foreach (margin_of[k]) margin_of[k] = 410;
            foreach (lo_lim[k]) begin
                lo_lim[k] = POS_LO;
                hi_lim[k] = POS_HI;
                tgt[k]    = 0;
                pos[k]    = 0;
            end
            loaded       = '0;
            skip_mask    = '0;
            active       = 1'b0;
            cancel_armed = 1'b0;
            errors       = 0;
            checked      = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [jgv_pkg::CFG_W-1:0] val);
            if (idx == jgv_pkg::REG_MAX_VEL) vel_limit = val;
            else if (idx == jgv_pkg::REG_DEADBAND) arrive_band = val;
            else margin_of[idx - jgv_pkg::REG_MARGIN1] = val;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        function void push(int j, int vel, jgv_pkg::t_status st);
            t_result r;
            r.joint  = jgv_pkg::JW'(j);
            r.vel    = POS_W'(vel);
            r.status = st;
            r.last   = 1'b0;
            due_q.push_back(r);
        endfunction

        function void zero_run(jgv_pkg::t_status st);
            for (int k = 0; k < jgv_pkg::JOINTS; k++) push(k, 0, st);
        endfunction

        function int clip(int v);
            return (v > POS_HI) ? POS_HI : ((v < POS_LO) ? POS_LO : v);
        endfunction

        function void note_command(logic [2:0] cmd, logic [2:0] jn,
                                   logic signed [POS_W-1:0] va,
                                   logic signed [POS_W-1:0] vb,
                                   logic [jgv_pkg::JOINTS-1:0] mask);
            int      n0, mg, lo_v, hi_v, err, mag, vel, bad;
            bit      done;
            t_result r;
            n0 = due_q.size();
            case (cmd)
                jgv_pkg::CMD_LOAD_LIMIT: if (jn < jgv_pkg::JOINTS) begin
                    mg = (jn == jgv_pkg::JAW) ? 0 : int'(margin_of[jn]);
                    lo_v = clip(int'(va) + mg);
                    hi_v = clip(int'(vb) - mg);
                    lo_lim[jn] = lo_v;
                    hi_lim[jn] = hi_v;
                    loaded[jn] = (lo_v <= hi_v);
                    push(jn, 0, (lo_v > hi_v) ? jgv_pkg::ST_EMPTY_RANGE : jgv_pkg::ST_OK);
                end
                jgv_pkg::CMD_SET_TARGET, jgv_pkg::CMD_POSITION: if (jn < jgv_pkg::JOINTS) begin
                    if (cmd == jgv_pkg::CMD_SET_TARGET) tgt[jn] = va;
                    else pos[jn] = va;
                    push(jn, 0, jgv_pkg::ST_OK);
                end
                jgv_pkg::CMD_START_GOAL: begin
                    if (loaded != '1) begin
                        push(0, 0, jgv_pkg::ST_NOT_READY);
                    end else begin
                        bad = -1;
                        for (int k = jgv_pkg::JOINTS - 1; k >= 0; k--)
                            if (!mask[k] && (tgt[k] < lo_lim[k] || tgt[k] > hi_lim[k])) bad = k;
                        if (bad >= 0) begin
                            push(bad, 0, jgv_pkg::ST_OUT_OF_RANGE);
                        end else begin
                            skip_mask    = mask;
                            active       = 1'b1;
                            cancel_armed = 1'b0;
                            push(0, 0, jgv_pkg::ST_OK);
                        end
                    end
                end
                jgv_pkg::CMD_TICK: begin
                    if (!active) begin
                        push(0, 0, jgv_pkg::ST_NOT_ACTIVE);
                    end else if (cancel_armed) begin
                        zero_run(jgv_pkg::ST_CANCELED);
                        active       = 1'b0;
                        cancel_armed = 1'b0;
                    end else begin
                        done = 1'b1;
                        for (int k = 0; k < jgv_pkg::JOINTS; k++) begin
                            vel = 0;
                            if (!skip_mask[k]) begin
                                err = tgt[k] - pos[k];
                                mag = (err < 0) ? -err : err;
                                if (mag > int'(arrive_band)) begin
                                    done = 1'b0;
                                    if (mag > int'(vel_limit)) mag = vel_limit;
                                    vel = (err < 0) ? -mag : mag;
                                end
                            end
                            push(k, vel, jgv_pkg::ST_MOVING);
                        end
                        if (done) begin
                            zero_run(jgv_pkg::ST_SUCCEEDED);
                            active = 1'b0;
                        end
                    end
                end
                jgv_pkg::CMD_CANCEL: begin
                    if (active) begin
                        zero_run(jgv_pkg::ST_STOP);
                        cancel_armed = 1'b1;
                    end else begin
                        push(0, 0, jgv_pkg::ST_NOT_ACTIVE);
                    end
                end
                default: ;
            endcase
            if (due_q.size() > n0) begin
                r = due_q.pop_back();
                r.last = 1'b1;
                due_q.push_back(r);
            end
        endfunction

        function void check_result(logic [jgv_pkg::JW-1:0] jr, logic signed [POS_W-1:0] v,
                                   logic [3:0] st, logic lst);
            t_result e;
            if (due_q.size() == 0) begin
                $error("unexpected result: joint_res %0d velocity %0d status %0d",
                       jr, v, st);
                errors++;
                return;
            end
            e = due_q.pop_front();
            checked++;
            if (jr !== e.joint) begin
                $error("joint_res: expected %0d, actual %0d", e.joint, jr);
                errors++;
            end
            if (v !== e.vel) begin
                $error("velocity: expected %0d, actual %0d", e.vel, v);
                errors++;
            end
            if (st !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, st);
                errors++;
            end
            if (lst !== e.last) begin
                $error("last: expected %0d, actual %0d", e.last, lst);
                errors++;
            end
        endfunction
    endclass

    // ---------------------------------------------------------------- signals
    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_in_valid    = 1'b0;
    logic                       o_in_stall;
    logic [2:0]                 i_cmd         = '0;
    logic [jgv_pkg::JW-1:0]     i_joint       = '0;
    logic signed [POS_W-1:0]    i_value_a     = '0;
    logic signed [POS_W-1:0]    i_value_b     = '0;
    logic [jgv_pkg::JOINTS-1:0] i_ignore_mask = '0;
    logic                       o_out_valid;
    logic                       i_out_stall   = 1'b0;
    logic [jgv_pkg::JW-1:0]     o_joint_res;
    logic signed [POS_W-1:0]    o_velocity;
    logic [3:0]                 o_status;
    logic                       o_last;
    logic                       psel          = 1'b0;
    logic                       penable       = 1'b0;
    logic                       pwrite        = 1'b0;
    logic [jgv_pkg::ADDR_W-1:0] paddr         = '0;
    logic [31:0]                pwdata        = '0;
    logic [31:0]                prdata;
    logic                       pready;

    goal_scoreboard sb = new();

    int gap_max  = 4;     // input side: idle cycles drawn per item
    int hold_max = 4;     // output side: stall cycles drawn per result
    int hold_left = 0;
    int n_sent   = 0;
    int cycles   = 0;

    joint_goal_velocity_controller #(.POS_WIDTH(POS_W)) dut (.*);

    always #6 i_clk = ~i_clk;

    // Hard stop in case the block hangs or drops a handshake.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: every accepted result goes to the scoreboard, then a
    // fresh stall length is drawn. Sampling at the edge sees pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_joint_res, o_velocity, o_status, o_last);
                hold_left = $urandom_range(0, hold_max);
            end else if (hold_left > 0) begin
                hold_left--;
            end
            i_out_stall <= (hold_left > 0);
        end
    end

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Present one command item and hold it until the block takes it. Always
    // returns on the accepting edge, so valid is only touched once per step.
    task automatic send_item(input logic [2:0] cmd, input logic [jgv_pkg::JW-1:0] jn,
                             input int va, input int vb,
                             input logic [jgv_pkg::JOINTS-1:0] mask);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_joint       <= jn;
        i_value_a     <= POS_W'(va);
        i_value_b     <= POS_W'(vb);
        i_ignore_mask <= mask;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_command(cmd, jn, POS_W'(va), POS_W'(vb), mask);
        n_sent++;
    endtask

    // Drain every expected result, then give the block time to settle after
    // any trailing item that produced nothing.
    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // APB write followed by a readback of the same register.
    task automatic cfg_write(input logic [2:0] idx, input logic [jgv_pkg::CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {17'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {17'd0, val}) begin
            $error("prdata: expected %0d, actual %0d", val, prdata);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Margins are drawn per joint from [mlo, mhi].
    task automatic configure(input int unsigned vmax, input int unsigned band,
                             input int unsigned mlo, input int unsigned mhi);
        cfg_write(jgv_pkg::REG_MAX_VEL, jgv_pkg::CFG_W'(vmax));
        cfg_write(jgv_pkg::REG_DEADBAND, jgv_pkg::CFG_W'(band));
        for (int k = 0; k < jgv_pkg::NMARGIN; k++)
            cfg_write(3'(jgv_pkg::REG_MARGIN1 + k), jgv_pkg::CFG_W'($urandom_range(mlo, mhi)));
    endtask

    // One goal episode: limits, targets, start, a few control rounds that
    // move some joints, and a final round that parks everything near target.
    // Occasionally the goal is canceled midway instead.
    task automatic run_episode(input bit reload_all);
        int   t, half, rounds;
        logic [jgv_pkg::JOINTS-1:0] mask;
        for (int j = 0; j < jgv_pkg::JOINTS; j++)
            if (reload_all || $urandom_range(0, 3) == 0)
                send_item(jgv_pkg::CMD_LOAD_LIMIT, jgv_pkg::JW'(j),
                          rand_between(-30000, -500), rand_between(500, 30000),
                          jgv_pkg::JOINTS'($urandom));
        for (int j = 0; j < jgv_pkg::JOINTS; j++) begin
            if ($urandom_range(0, 7) == 0 || sb.lo_lim[j] > sb.hi_lim[j])
                t = rand_between(POS_LO, POS_HI);
            else
                t = rand_between(sb.lo_lim[j], sb.hi_lim[j]);
            send_item(jgv_pkg::CMD_SET_TARGET, jgv_pkg::JW'(j), t,
                      int'($urandom_range(0, 65535)) - 32768, jgv_pkg::JOINTS'($urandom));
        end
        mask = ($urandom_range(0, 2) == 0) ? jgv_pkg::JOINTS'($urandom) : '0;
        send_item(jgv_pkg::CMD_START_GOAL, jgv_pkg::JW'($urandom_range(0, 7)),
                  rand_between(POS_LO, POS_HI), rand_between(POS_LO, POS_HI), mask);
        rounds = $urandom_range(1, 3);
        for (int r = 0; r < rounds; r++) begin
            repeat (2)
                send_item(jgv_pkg::CMD_POSITION,
                          jgv_pkg::JW'($urandom_range(0, jgv_pkg::JOINTS - 1)),
                          rand_between(-12000, 12000), 0, '0);
            send_item(jgv_pkg::CMD_TICK, '0, 0, 0, '0);
            if ($urandom_range(0, 5) == 0) begin
                send_item(jgv_pkg::CMD_CANCEL, '0, 0, 0, '0);
                send_item(jgv_pkg::CMD_TICK, '0, 0, 0, '0);
                return;
            end
        end
        half = sb.arrive_band / 2;
        for (int j = 0; j < jgv_pkg::JOINTS; j++) begin
            t = sb.tgt[j];
            send_item(jgv_pkg::CMD_POSITION, jgv_pkg::JW'(j),
                      rand_between((t - half < POS_LO) ? POS_LO : t - half,
                                   (t + half > POS_HI) ? POS_HI : t + half), 0, '0);
        end
        send_item(jgv_pkg::CMD_TICK, '0, 0, 0, '0);
        send_item(jgv_pkg::CMD_TICK, '0, 0, 0, '0);
    endtask

    initial begin
        int first_item;
        bit fresh;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed: reset defaults (max velocity 2048, deadband and margins 410)
        send_item(jgv_pkg::CMD_TICK, '0, 0, 0, '0);                 // tick with no goal
        send_item(jgv_pkg::CMD_CANCEL, '0, 0, 0, '0);               // cancel with no goal
        send_item(jgv_pkg::CMD_START_GOAL, '0, 0, 0, '0);           // limits not loaded yet
        send_item(CMD_SPARE_6, '0, 0, 0, '0);                       // unknown commands: dropped
        send_item(CMD_SPARE_7, NO_JOINT, POS_HI, -1, '1);
        send_item(jgv_pkg::CMD_LOAD_LIMIT, NO_JOINT, -100, 100, '0); // joint out of range
        send_item(jgv_pkg::CMD_SET_TARGET, NO_JOINT, 5, 0, '0);
        // saturating shrink on both ends, leaves an empty range
        send_item(jgv_pkg::CMD_LOAD_LIMIT, 3'd1, POS_HI, POS_LO, '0);
        send_item(jgv_pkg::CMD_LOAD_LIMIT, 3'd0, POS_LO, POS_HI, '0);
        for (int j = 1; j < jgv_pkg::NMARGIN; j++)
            send_item(jgv_pkg::CMD_LOAD_LIMIT, jgv_pkg::JW'(j), -8192, 8192, '0);
        send_item(jgv_pkg::CMD_LOAD_LIMIT, jgv_pkg::JAW, -1000, 1000, '0); // jaw: no margin
        send_item(jgv_pkg::CMD_SET_TARGET, 3'd3, 9000, 0, '0);     // past shrunk upper limit
        send_item(jgv_pkg::CMD_START_GOAL, '0, 0, 0, '0);           // rejected on joint 3
        send_item(jgv_pkg::CMD_START_GOAL, '0, 0, 0, 7'b0001000);   // joint 3 masked
        send_item(jgv_pkg::CMD_POSITION, 3'd0, POS_LO, 0, '0);      // huge error, clamped
        send_item(jgv_pkg::CMD_TICK, '0, 0, 0, '0);
        send_item(jgv_pkg::CMD_CANCEL, '0, 0, 0, '0);               // stop run, cancel pending
        send_item(jgv_pkg::CMD_START_GOAL, '0, 0, 0, 7'b0001000);   // new goal drops cancel
        send_item(jgv_pkg::CMD_TICK, '0, 0, 0, '0);
        send_item(jgv_pkg::CMD_CANCEL, '0, 0, 0, '0);
        send_item(jgv_pkg::CMD_TICK, '0, 0, 0, '0);                 // canceled run ends goal
        send_item(jgv_pkg::CMD_START_GOAL, '0, 0, 0, '1);           // all masked
        send_item(jgv_pkg::CMD_TICK, '0, 0, 0, '0);                 // arrives at once
        quiesce();

        // ---- random phases, each under its own register setting
        for (int p = 0; p < 3; p++) begin
            gap_max  = 4;
            hold_max = 4;
            case (p)
                0: configure($urandom_range(500, 8000), $urandom_range(0, 1000), 0, 2000);
                1: begin
                    configure(0, 0, 0, 0);               // low extremes, no idling at all
                    gap_max  = 0;
                    hold_max = 0;
                end
                default: configure(32767, 32767, 32767, 32767); // high extremes
            endcase
            first_item = n_sent;
            fresh = 1'b1;
            while (n_sent - first_item < 22) begin
                run_episode(fresh);
                fresh = 1'b0;
            end
            // unconstrained items to toggle every field bit
            repeat (3)
                send_item(3'($urandom_range(0, 7)), jgv_pkg::JW'($urandom_range(0, 7)),
                          int'($urandom_range(0, 65535)) - 32768,
                          int'($urandom_range(0, 65535)) - 32768,
                          jgv_pkg::JOINTS'($urandom));
            quiesce();
        end

        $display("%0d command items sent, %0d results checked", n_sent, sb.checked);
        $display("covered reset defaults and three register settings incl. both extremes");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/jgv_pkg.sv
rtl/jgv_alu.sv
rtl/jgv_regfile.sv
rtl/joint_goal_velocity_controller.sv
bench/testbench.sv
